// File: src/structure_tensor_eigen_analysis_top_defines.svh
// assertion macros for the checker file of the block
`ifndef STRUCTURE_TENSOR_EIGEN_ANALYSIS_TOP_DEFINES_SVH
`define STRUCTURE_TENSOR_EIGEN_ANALYSIS_TOP_DEFINES_SVH

// clocked assertion, quiet while reset is held
`define STEA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// invariant that holds in every cycle outside reset
`define STEA_ASSERT_ALWAYS(label, expr, msg) \
  `STEA_ASSERT(label, expr, msg)

`endif

// File: src/stea_pkg.sv
// widths, latencies, constants and the arctangent table of the eigen analysis block
package stea_pkg;

  localparam int unsigned COMP_W     = 24;
  localparam int unsigned XY_W       = 25;
  localparam int unsigned DIFF_W     = 25;
  localparam int unsigned TRACE_W    = 25;
  localparam int unsigned DSQ_W      = 48;
  localparam int unsigned XSQ_W      = 49;
  localparam int unsigned S_W        = 51;
  localparam int unsigned S_SHIFT    = 8;
  localparam int unsigned ROOT_IN_W  = 60;
  localparam int unsigned ROOT_W     = ROOT_IN_W / 2;
  localparam int unsigned MAG_IN_W   = 30;
  localparam int unsigned MAG_W      = MAG_IN_W / 2;
  localparam int unsigned OUT_W      = 16;
  localparam int unsigned COH_SHIFT  = 11;
  localparam int unsigned NUM_W      = ROOT_W + COH_SHIFT;
  localparam int unsigned QUO_W      = 15;

  localparam int unsigned CORDIC_STEPS = 18;
  localparam int unsigned CX_W         = 40;
  localparam int unsigned Z_W          = 23;
  localparam int unsigned CX_SHIFT     = 12;
  localparam int unsigned CORDIC_STG   = CORDIC_STEPS + 2;

  // register positions counted from the input transaction
  localparam int unsigned ROOT_DONE = 2 + ROOT_W;
  localparam int unsigned ANG_DLY   = ROOT_DONE + 1 - (1 + CORDIC_STG);
  localparam int unsigned LAT       = ROOT_DONE + 1 + MAG_W + 1;

  localparam logic [OUT_W-1:0]       COH_ONE  = 16'd32768;
  localparam logic signed [Z_W-1:0]  ANG_HALF = 23'sd524288;
  localparam logic [20:0]            ANG_BIAS = 21'h100020;
  localparam logic [QUO_W-1:0]       ANG_WRAP = 15'd16383;

  localparam int unsigned        CFG_ADDR_W       = 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TRACE_FLOOR = 2'd0;

  // arctangent of 2^-i, pi = 2^20
  function automatic logic signed [Z_W-1:0] atan_tab(input int unsigned i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:       v = 23'sd262144;
      1:       v = 23'sd154753;
      2:       v = 23'sd81767;
      3:       v = 23'sd41506;
      4:       v = 23'sd20834;
      5:       v = 23'sd10427;
      6:       v = 23'sd5215;
      7:       v = 23'sd2608;
      8:       v = 23'sd1304;
      9:       v = 23'sd652;
      10:      v = 23'sd326;
      11:      v = 23'sd163;
      12:      v = 23'sd81;
      13:      v = 23'sd41;
      14:      v = 23'sd20;
      15:      v = 23'sd10;
      16:      v = 23'sd5;
      17:      v = 23'sd3;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: src/stea_sqrt_pipe.sv
// pipelined integer square root, one result bit per stage, with a sideband
module stea_sqrt_pipe #(
  parameter int unsigned IN_W   = stea_pkg::ROOT_IN_W,
  parameter int unsigned SIDE_W = stea_pkg::TRACE_W
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [IN_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int unsigned RW    = IN_W / 2;
  localparam int unsigned REM_W = RW + 2;

  logic [REM_W-1:0]  rem_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [IN_W-1:0]   rest_q [RW];
  logic [SIDE_W-1:0] side_q [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stg
    logic [REM_W-1:0]  rem_p, rem_sh, trial, rem_d;
    logic [RW-1:0]     root_p, root_d;
    logic [IN_W-1:0]   rest_p, rest_d;
    logic [SIDE_W-1:0] side_p;
    logic              ge;

    if (g == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rest_p = rad_i;
      assign side_p = side_i;
    end else begin : g_next
      assign rem_p  = rem_q[g-1];
      assign root_p = root_q[g-1];
      assign rest_p = rest_q[g-1];
      assign side_p = side_q[g-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_p[REM_W-3:0], rest_p[IN_W-1 -: 2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = (rem_sh >= trial);
    assign rem_d  = ge ? (rem_sh - trial) : rem_sh;
    assign root_d = {root_p[RW-2:0], ge};
    assign rest_d = {rest_p[IN_W-3:0], 2'b00};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
        rest_q[g] <= rest_d;
        side_q[g] <= side_p;
      end
    end
  end

  assign root_o = root_q[RW-1];
  assign side_o = side_q[RW-1];

endmodule

// File: src/stea_div_pipe.sv
// coherence divider: root*2048/trace, one quotient bit per stage, saturated, zero when trace <= floor
module stea_div_pipe (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [stea_pkg::ROOT_W-1:0]       root_i,
  input  logic [stea_pkg::TRACE_W-1:0]      trace_i,
  input  logic [stea_pkg::COMP_W-1:0]       floor_i,
  output logic [stea_pkg::OUT_W-1:0]        coh_o
);

  localparam int unsigned NW = stea_pkg::NUM_W;
  localparam int unsigned QW = stea_pkg::QUO_W;
  localparam int unsigned TW = stea_pkg::TRACE_W;

  logic [NW-1:0] pre_rem_q;
  logic [TW-1:0] pre_trace_q;
  logic          pre_sat_q, pre_zero_q;
  logic          sat_d, zero_d;

  // quotient would reach one when root >= 16*trace
  assign sat_d  = (root_i >= {1'b0, trace_i, 4'b0000});
  assign zero_d = ({1'b0, floor_i} >= trace_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pre_rem_q   <= {root_i, {stea_pkg::COH_SHIFT{1'b0}}};
      pre_trace_q <= trace_i;
      pre_sat_q   <= sat_d;
      pre_zero_q  <= zero_d;
    end
  end

  logic [NW-1:0] rem_q   [QW];
  logic [QW-1:0] quo_q   [QW];
  logic [TW-1:0] trace_q [QW];
  logic          sat_q   [QW];
  logic          zero_q  [QW];

  for (genvar g = 0; g < QW; g++) begin : g_stg
    localparam int unsigned K = QW - 1 - g;
    logic [NW-1:0] rem_p, dvs, rem_d;
    logic [QW-1:0] quo_p, quo_d;
    logic [TW-1:0] trace_p;
    logic          sat_p, zero_p, ge;

    if (g == 0) begin : g_first
      assign rem_p   = pre_rem_q;
      assign quo_p   = '0;
      assign trace_p = pre_trace_q;
      assign sat_p   = pre_sat_q;
      assign zero_p  = pre_zero_q;
    end else begin : g_next
      assign rem_p   = rem_q[g-1];
      assign quo_p   = quo_q[g-1];
      assign trace_p = trace_q[g-1];
      assign sat_p   = sat_q[g-1];
      assign zero_p  = zero_q[g-1];
    end

    assign dvs   = NW'(trace_p) << K;
    assign ge    = (rem_p >= dvs);
    assign rem_d = ge ? (rem_p - dvs) : rem_p;
    assign quo_d = {quo_p[QW-2:0], ge};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]   <= rem_d;
        quo_q[g]   <= quo_d;
        trace_q[g] <= trace_p;
        sat_q[g]   <= sat_p;
        zero_q[g]  <= zero_p;
      end
    end
  end

  always_comb begin
    if (zero_q[QW-1]) begin
      coh_o = '0;
    end else if (sat_q[QW-1]) begin
      coh_o = stea_pkg::COH_ONE;
    end else begin
      coh_o = {1'b0, quo_q[QW-1]};
    end
  end

endmodule

// File: src/stea_cordic_pipe.sv
// vectoring cordic for half atan2, quarter turn offset and wrap to the output angle
module stea_cordic_pipe (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [stea_pkg::DIFF_W-1:0]   diff_i,
  input  logic signed [stea_pkg::XY_W-1:0]     xy_i,
  output logic signed [stea_pkg::OUT_W-1:0]    angle_o
);

  localparam int unsigned XW = stea_pkg::CX_W;
  localparam int unsigned ZW = stea_pkg::Z_W;
  localparam int unsigned NS = stea_pkg::CORDIC_STEPS;

  logic signed [XW-1:0] x0, y0, xr_d, yr_d;
  logic signed [ZW-1:0] zr_d;
  logic                 zero_d;

  // x = diff*4096, y = 2*xy*4096
  assign x0 = {{(XW - stea_pkg::DIFF_W - stea_pkg::CX_SHIFT){diff_i[stea_pkg::DIFF_W-1]}},
               diff_i, {stea_pkg::CX_SHIFT{1'b0}}};
  assign y0 = {{(XW - stea_pkg::XY_W - stea_pkg::CX_SHIFT - 1){xy_i[stea_pkg::XY_W-1]}},
               xy_i, {(stea_pkg::CX_SHIFT + 1){1'b0}}};
  assign zero_d = (diff_i == '0) && (xy_i == '0);

  // left half plane: pre-rotate by a quarter turn
  always_comb begin
    if (x0 < 0) begin
      if (y0 >= 0) begin
        xr_d = y0;
        yr_d = -x0;
        zr_d = stea_pkg::ANG_HALF;
      end else begin
        xr_d = -y0;
        yr_d = x0;
        zr_d = -stea_pkg::ANG_HALF;
      end
    end else begin
      xr_d = x0;
      yr_d = y0;
      zr_d = '0;
    end
  end

  logic signed [XW-1:0] x_q    [NS+1];
  logic signed [XW-1:0] y_q    [NS+1];
  logic signed [ZW-1:0] z_q    [NS+1];
  logic                 zero_q [NS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= xr_d;
      y_q[0]    <= yr_d;
      z_q[0]    <= zr_d;
      zero_q[0] <= zero_d;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_iter
    logic signed [XW-1:0] xs, ys, x_d, y_d;
    logic signed [ZW-1:0] z_d;

    assign xs = x_q[g] >>> g;
    assign ys = y_q[g] >>> g;

    always_comb begin
      if (y_q[g] > 0) begin
        x_d = x_q[g] + ys;
        y_d = y_q[g] - xs;
        z_d = z_q[g] + stea_pkg::atan_tab(g);
      end else begin
        x_d = x_q[g] - ys;
        y_d = y_q[g] + xs;
        z_d = z_q[g] - stea_pkg::atan_tab(g);
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[g+1]    <= x_d;
        y_q[g+1]    <= y_d;
        z_q[g+1]    <= z_d;
        zero_q[g+1] <= zero_q[g];
      end
    end
  end

  // only the low 21 bits of the sum reach the wrapped result
  logic [20:0]                        sum_w;
  logic [stea_pkg::QUO_W-1:0]         wrap_w;
  logic signed [stea_pkg::OUT_W-1:0]  ang_d, ang_q;

  assign sum_w  = (zero_q[NS] ? 21'd0 : z_q[NS][20:0]) + stea_pkg::ANG_BIAS;
  assign wrap_w = sum_w[20:6] + stea_pkg::ANG_WRAP;
  assign ang_d  = $signed({1'b0, wrap_w}) - $signed({1'b0, stea_pkg::ANG_WRAP});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ang_q <= ang_d;
    end
  end

  assign angle_o = ang_q;

endmodule

// File: src/structure_tensor_eigen_analysis_top.sv
// structure tensor eigen analysis: orientation, coherence and magnitude per pixel
//
// input channel carries one smoothed tensor (xx, yy, xy) per transaction and
// output channel one result (flow_angle, coherence, magnitude); both use
// valid/stall, a transaction moves when valid is high and stall is low.
// trace_floor sits at byte address 0 of the apb-style port; pready is tied high.
// the datapath is one pipeline of 49 register stages: squares, sum, a 30-stage
// square root of the discriminant, then a 15-bit divider for coherence beside a
// 15-stage square root for magnitude; the cordic angle runs alongside.
// throughput is one transaction per cycle while the output is not stalled.
// the whole pipeline advances together; when the output is valid and stalled
// every stage holds and in_stall_o is raised, so nothing is dropped or repeated.
// reset clears the stage valid bits and trace_floor; stage data is not reset.
module structure_tensor_eigen_analysis_top (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic [stea_pkg::COMP_W-1:0]              tensor_xx_i,
  input  logic [stea_pkg::COMP_W-1:0]              tensor_yy_i,
  input  logic signed [stea_pkg::XY_W-1:0]         tensor_xy_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [stea_pkg::OUT_W-1:0]        flow_angle_o,
  output logic [stea_pkg::OUT_W-1:0]               coherence_o,
  output logic [stea_pkg::OUT_W-1:0]               magnitude_o,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [stea_pkg::CFG_ADDR_W-1:0]          paddr,
  input  logic [31:0]                              pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  localparam int unsigned LAT = stea_pkg::LAT;

  logic adv;
  logic [LAT-1:0] vld_q;

  assign adv        = !vld_q[LAT-1] || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // configuration register
  logic [stea_pkg::COMP_W-1:0] trace_floor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trace_floor_q <= '0;
    end else if (psel && penable && pwrite && (paddr == stea_pkg::ADDR_TRACE_FLOOR)) begin
      trace_floor_q <= pwdata[stea_pkg::COMP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == stea_pkg::ADDR_TRACE_FLOOR) ?
                  {{(32 - stea_pkg::COMP_W){1'b0}}, trace_floor_q} : '0;

  // stage 1: difference, trace and squares
  logic signed [stea_pkg::DIFF_W-1:0]  diff_w, diff1_q;
  logic [stea_pkg::TRACE_W-1:0]        trace1_q, trace2_q;
  logic signed [stea_pkg::XY_W-1:0]    xy1_q;
  logic signed [2*stea_pkg::DIFF_W-1:0] dprod_w, xprod_w;
  logic [stea_pkg::DSQ_W-1:0]          dsq1_q;
  logic [stea_pkg::XSQ_W-1:0]          xsq1_q;
  logic [stea_pkg::S_W-1:0]            s2_q;

  assign diff_w  = $signed({1'b0, tensor_xx_i}) - $signed({1'b0, tensor_yy_i});
  assign dprod_w = diff_w * diff_w;
  assign xprod_w = tensor_xy_i * tensor_xy_i;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      diff1_q  <= diff_w;
      xy1_q    <= tensor_xy_i;
      trace1_q <= {1'b0, tensor_xx_i} + {1'b0, tensor_yy_i};
      dsq1_q   <= dprod_w[stea_pkg::DSQ_W-1:0];
      xsq1_q   <= xprod_w[stea_pkg::XSQ_W-1:0];
    end
  end

  // stage 2: discriminant (xx-yy)^2 + 4xy^2
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q     <= stea_pkg::S_W'(dsq1_q) + {xsq1_q, 2'b00};
      trace2_q <= trace1_q;
    end
  end

  logic [stea_pkg::ROOT_W-1:0]  root_w;
  logic [stea_pkg::TRACE_W-1:0] trace_r_w;

  stea_sqrt_pipe #(
    .IN_W   (stea_pkg::ROOT_IN_W),
    .SIDE_W (stea_pkg::TRACE_W)
  ) u_root (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  ({1'b0, s2_q, {stea_pkg::S_SHIFT{1'b0}}}),
    .side_i (trace2_q),
    .root_o (root_w),
    .side_o (trace_r_w)
  );

  logic [stea_pkg::OUT_W-1:0] coh_w;

  stea_div_pipe u_div (
    .clk_i   (clk_i),
    .en_i    (adv),
    .root_i  (root_w),
    .trace_i (trace_r_w),
    .floor_i (trace_floor_q),
    .coh_o   (coh_w)
  );

  // angle path, delayed to meet the magnitude root
  logic signed [stea_pkg::OUT_W-1:0] cordic_w;
  logic signed [stea_pkg::OUT_W-1:0] ang_dly_q [stea_pkg::ANG_DLY];

  stea_cordic_pipe u_cordic (
    .clk_i   (clk_i),
    .en_i    (adv),
    .diff_i  (diff1_q),
    .xy_i    (xy1_q),
    .angle_o (cordic_w)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang_dly_q[0] <= cordic_w;
      for (int i = 1; i < stea_pkg::ANG_DLY; i++) begin
        ang_dly_q[i] <= ang_dly_q[i-1];
      end
    end
  end

  // magnitude radicand (16*trace + root) / 2
  logic [stea_pkg::MAG_IN_W:0]   mag_sum_w;
  logic [stea_pkg::MAG_IN_W-1:0] mag_rad_q;
  logic [stea_pkg::MAG_W-1:0]    mag_w;
  logic signed [stea_pkg::OUT_W-1:0] ang_w;

  assign mag_sum_w = {2'b00, trace_r_w, 4'b0000} + {1'b0, root_w};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_rad_q <= mag_sum_w[stea_pkg::MAG_IN_W:1];
    end
  end

  stea_sqrt_pipe #(
    .IN_W   (stea_pkg::MAG_IN_W),
    .SIDE_W (stea_pkg::OUT_W)
  ) u_mag (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (mag_rad_q),
    .side_i (ang_dly_q[stea_pkg::ANG_DLY-1]),
    .root_o (mag_w),
    .side_o (ang_w)
  );

  // output register
  logic signed [stea_pkg::OUT_W-1:0] flow_angle_q;
  logic [stea_pkg::OUT_W-1:0]        coherence_q, magnitude_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      flow_angle_q <= ang_w;
      coherence_q  <= coh_w;
      magnitude_q  <= {1'b0, mag_w};
    end
  end

  assign out_valid_o  = vld_q[LAT-1];
  assign flow_angle_o = flow_angle_q;
  assign coherence_o  = coherence_q;
  assign magnitude_o  = magnitude_q;

endmodule

// File: src/stea_checker.sv
// port checker for the eigen analysis block and its bind
`include "structure_tensor_eigen_analysis_top_defines.svh"

module stea_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic [stea_pkg::COMP_W-1:0]          tensor_xx_i,
  input logic [stea_pkg::COMP_W-1:0]          tensor_yy_i,
  input logic signed [stea_pkg::XY_W-1:0]     tensor_xy_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [stea_pkg::OUT_W-1:0]    flow_angle_o,
  input logic [stea_pkg::OUT_W-1:0]           coherence_o,
  input logic [stea_pkg::OUT_W-1:0]           magnitude_o,
  input logic                                 psel,
  input logic                                 penable,
  input logic                                 pwrite,
  input logic [stea_pkg::CFG_ADDR_W-1:0]      paddr,
  input logic [31:0]                          pwdata,
  input logic [31:0]                          prdata,
  input logic                                 pready
);

  // input only backs up behind a stalled result
  `STEA_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled without a blocked result")

  // a blocked result holds
  `STEA_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(coherence_o) && $stable(magnitude_o) && $stable(flow_angle_o)), "stalled result changed")

  // result fields stay in their ranges
  `STEA_ASSERT(a_out_range, out_valid_o |-> ((coherence_o <= stea_pkg::COH_ONE) && (flow_angle_o >= -16'sd16383) && (flow_angle_o <= 16'sd16384)), "result out of range")

  // a write to trace_floor reads back
  `STEA_ASSERT(a_cfg_readback, (psel && penable && pwrite && pready && (paddr == stea_pkg::ADDR_TRACE_FLOOR)) |=> ((paddr != stea_pkg::ADDR_TRACE_FLOOR) || (prdata[stea_pkg::COMP_W-1:0] == $past(pwdata[stea_pkg::COMP_W-1:0]))), "trace_floor readback mismatch")

  `STEA_ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind structure_tensor_eigen_analysis_top stea_checker u_stea_checker (.*);

// File: sim/tb.sv
// self-checking testbench for the structure tensor eigen analysis block
`timescale 1ns / 100ps

module tb;

  localparam int unsigned COMP_W    = stea_pkg::COMP_W;
  localparam int unsigned XY_W      = stea_pkg::XY_W;
  localparam int unsigned OUT_W     = stea_pkg::OUT_W;
  localparam int unsigned PIPE_LAT  = stea_pkg::LAT;
  localparam int unsigned WDOG_MAX  = 2000;
  localparam int unsigned N_RANDOM  = 1530;

  typedef struct packed {
    logic [COMP_W-1:0]       xx;
    logic [COMP_W-1:0]       yy;
    logic signed [XY_W-1:0]  xy;
  } tensor_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] angle;
    logic [OUT_W-1:0]        coh;
    logic [OUT_W-1:0]        mag;
  } eigen_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o;
  logic [COMP_W-1:0] tensor_xx_i = '0;
  logic [COMP_W-1:0] tensor_yy_i = '0;
  logic signed [XY_W-1:0] tensor_xy_i = '0;
  logic signed [OUT_W-1:0] flow_angle_o;
  logic [OUT_W-1:0] coherence_o, magnitude_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic pready;
  logic [stea_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;

  structure_tensor_eigen_analysis_top u_top (.*);

  tensor_t  pending_q[$];
  eigen_t   expected_q[$];
  logic [COMP_W-1:0] floor_reg;
  int n_errors, n_checked, n_sent, wdog;
  int in_wait, out_wait;

  always begin
    clk_i = 1'b1; #4;
    clk_i = 1'b0; #4;
  end

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint orient_atan2(input longint y, input longint x);
    longint z, t, xs, ys;
    longint tab[18] = '{262144, 154753, 81767, 41506, 20834, 10427, 5215, 2608,
                        1304, 652, 326, 163, 81, 41, 20, 10, 5, 3};
    z = 0;
    if (x == 0 && y == 0) return 0;
    x = x * 4096;
    y = y * 4096;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 524288;
      end else begin
        t = x; x = -y; y = t; z = -524288;
      end
    end
    for (int i = 0; i < 18; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z += tab[i];
      end else begin
        x = x - ys; y = y + xs; z -= tab[i];
      end
    end
    return z;
  endfunction

  function automatic eigen_t predict_eigen(input tensor_t tn);
    longint xx, yy, xy, diff, a, t;
    logic [63:0] trace, s, root, coh, mag;
    eigen_t r;
    xx = longint'(tn.xx);
    yy = longint'(tn.yy);
    xy = longint'(tn.xy);
    diff = xx - yy;
    trace = xx + yy;
    s = diff * diff + 4 * xy * xy;
    root = int_sqrt(s << 8);
    if (trace <= {40'd0, floor_reg}) begin
      coh = 0;
    end else begin
      coh = (root * 2048) / trace;
      if (coh > 32768) coh = 32768;
    end
    mag = int_sqrt((trace * 16 + root) >> 1);
    if (mag > 65535) mag = 65535;
    a = orient_atan2(2 * xy, diff);
    t = (a + 1048576 + 32) >>> 6;
    t = ((t + 16383) & 32767) - 16383;
    r.angle = t[15:0];
    r.coh = coh[15:0];
    r.mag = mag[15:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_errors++;
  endtask

  // driver: one queued tensor per transaction, random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      tensor_xx_i <= '0;
      tensor_yy_i <= '0;
      tensor_xy_i <= '0;
      in_wait = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_q.push_back(predict_eigen({tensor_xx_i, tensor_yy_i, tensor_xy_i}));
        n_sent++;
        in_wait = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) in_wait = 0;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (in_wait > 0 || pending_q.size() == 0) begin
          in_valid_i <= 1'b0;
          if (in_wait > 0) in_wait--;
        end else begin
          tensor_t tn;
          tn = pending_q.pop_front();
          in_valid_i  <= 1'b1;
          tensor_xx_i <= tn.xx;
          tensor_yy_i <= tn.yy;
          tensor_xy_i <= tn.xy;
        end
      end
    end
  end

  // monitor with random receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        eigen_t w;
        n_checked++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected transaction", 0, 0);
        end else begin
          w = expected_q.pop_front();
          if (flow_angle_o !== w.angle)
            report_mismatch("flow_angle", int'(flow_angle_o), int'(w.angle));
          if (coherence_o !== w.coh)
            report_mismatch("coherence", int'(coherence_o), int'(w.coh));
          if (magnitude_o !== w.mag)
            report_mismatch("magnitude", int'(magnitude_o), int'(w.mag));
        end
        out_wait = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 3);
      end
      if (out_wait > 0) begin
        out_stall_i <= 1'b1;
        out_wait--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel
        || (pending_q.size() == 0 && expected_q.size() == 0)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_MAX) begin
      $display("FAILURE");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  task automatic write_floor(input logic [COMP_W-1:0] v);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= stea_pkg::ADDR_TRACE_FLOOR; pwdata <= {8'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    floor_reg = v;
  endtask

  task automatic drain;
    while (pending_q.size() != 0 || expected_q.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (PIPE_LAT + 4) @(posedge clk_i);
  endtask

  function automatic tensor_t rand_tensor();
    tensor_t tn;
    int m;
    m = $urandom_range(0, 3);
    tn.xx = COMP_W'($urandom);
    tn.yy = COMP_W'($urandom);
    tn.xy = XY_W'($urandom);
    // one in four small magnitudes, one in four equal diagonals, the rest full range
    if (m == 0) begin
      tn.xx = COMP_W'($urandom_range(0, 4095));
      tn.yy = COMP_W'($urandom_range(0, 4095));
      tn.xy = XY_W'($signed($urandom_range(0, 8191)) - 4096);
    end else if (m == 1) begin
      tn.yy = tn.xx;
      if ($urandom_range(0, 1)) tn.xy = '0;
    end
    return tn;
  endfunction

  function automatic tensor_t mk(input int a, input int b, input int c);
    tensor_t tn;
    tn.xx = COMP_W'(a); tn.yy = COMP_W'(b); tn.xy = XY_W'(c);
    return tn;
  endfunction

  initial begin
    n_errors = 0; n_checked = 0; n_sent = 0;
    floor_reg = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, zero vector, below-floor, non-psd tensors
    pending_q.push_back(mk(0, 0, 0));
    pending_q.push_back(mk(100, 100, 0));
    pending_q.push_back(mk(24'hFFFFFF, 24'hFFFFFF, 0));
    pending_q.push_back(mk(24'hFFFFFF, 0, 0));
    pending_q.push_back(mk(0, 24'hFFFFFF, 0));
    pending_q.push_back(mk(0, 0, 25'h0FFFFFF));
    pending_q.push_back(mk(0, 0, -16777216));
    pending_q.push_back(mk(24'hFFFFFF, 0, 25'h0FFFFFF));
    pending_q.push_back(mk(0, 24'hFFFFFF, -16777216));
    pending_q.push_back(mk(24'hFFFFFF, 24'hFFFFFF, -16777216));
    pending_q.push_back(mk(16, 16, 16));
    pending_q.push_back(mk(16, 16, -16));
    pending_q.push_back(mk(1, 0, 0));
    pending_q.push_back(mk(0, 1, 0));
    pending_q.push_back(mk(0, 1, -1));
    pending_q.push_back(mk(5, 3, 1));
    pending_q.push_back(mk(3, 5, -1));
    drain();

    write_floor(24'hFFFFFF);
    pending_q.push_back(mk(24'hFFFFFF, 0, 7));
    pending_q.push_back(mk(24'hFFFFFF, 24'hFFFFFF, 0));
    pending_q.push_back(mk(24'h800000, 24'h7FFFFF, 5));
    for (int i = 0; i < 100; i++) pending_q.push_back(rand_tensor());
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_floor(24'd0);
        1: write_floor(24'd4096);
        2: write_floor(COMP_W'($urandom));
        3: write_floor(24'd1);
        default: write_floor(24'd0);
      endcase
      for (int i = 0; i < N_RANDOM / 5; i++) pending_q.push_back(rand_tensor());
      drain();
    end

    $display("%0d tensors sent, %0d results checked over 7 trace floor settings",
             n_sent, n_checked);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
